// ----- sv/tlc_pkg.sv -----
// Shared types, codes and helpers for the tape language processor.
`timescale 1ns / 1ps

package tlc_pkg;

	typedef struct packed {
		logic [1:0]  func;
		logic [11:0] prog_addr;
		logic [7:0]  prog_byte;
		logic [7:0]  in_byte;
		logic        in_valid;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  out_byte;
		logic [11:0] program_counter;
	} rsp_t;

	localparam logic [1:0] FN_LOAD    = 2'd0;
	localparam logic [1:0] FN_EXEC    = 2'd1;
	localparam logic [1:0] FN_RESTART = 2'd2;

	localparam logic [2:0] ST_STEPPED   = 3'd0;
	localparam logic [2:0] ST_BYTE_OUT  = 3'd1;
	localparam logic [2:0] ST_HALTED    = 3'd2;
	localparam logic [2:0] ST_NEED_IN   = 3'd3;
	localparam logic [2:0] ST_STK_EMPTY = 3'd4;
	localparam logic [2:0] ST_STK_OVF   = 3'd5;
	localparam logic [2:0] ST_UNMATCHED = 3'd6;
	localparam logic [2:0] ST_PTR_RANGE = 3'd7;

	localparam logic [7:0] CH_RIGHT = 8'h3E;
	localparam logic [7:0] CH_LEFT  = 8'h3C;
	localparam logic [7:0] CH_INC   = 8'h2B;
	localparam logic [7:0] CH_DEC   = 8'h2D;
	localparam logic [7:0] CH_OUT   = 8'h2E;
	localparam logic [7:0] CH_IN    = 8'h2C;
	localparam logic [7:0] CH_OPEN  = 8'h5B;
	localparam logic [7:0] CH_CLOSE = 8'h5D;
	localparam logic [7:0] CH_GOTO  = 8'h26;
	localparam logic [7:0] CH_CALL  = 8'h40;
	localparam logic [7:0] CH_RET   = 8'h24;
	localparam logic [7:0] CH_POP   = 8'h5E;

	typedef enum logic [3:0] {
		OPC_HALT, OPC_RIGHT, OPC_LEFT, OPC_INC, OPC_DEC, OPC_OUT, OPC_IN,
		OPC_OPEN, OPC_CLOSE, OPC_GOTO, OPC_CALL, OPC_RET, OPC_POP, OPC_NOP
	} opc_t;

	typedef enum logic [4:0] {
		ACT_NONE, ACT_ADV, ACT_DP_INC, ACT_DP_DEC, ACT_CELL_INC, ACT_CELL_DEC,
		ACT_CELL_IN, ACT_DP_SET, ACT_OUT, ACT_PUSH_ADV, ACT_LOOP_POP,
		ACT_LOOP_BACK, ACT_CALL_PUSH, ACT_CALL_JUMP, ACT_RET, ACT_POP,
		ACT_SCAN_JUMP, ACT_HALT, ACT_PM_WR, ACT_RESTART
	} act_t;

	typedef struct packed {
		logic       latch;
		logic       mod_start;
		logic       mod_sel_cell;
		logic       scan_start;
		logic       scan_rd;
		logic       scan_chk;
		logic       clr_step;
		logic       res_load;
		logic [2:0] res_code;
		act_t       act;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		opc_t       opc;
		logic       halted;
		logic       cell_zero;
		logic       dp_oor;
		logic       sc_empty;
		logic       sc_full;
		logic       in_avail;
		logic       scan_at_end;
		logic       scan_zero;
		logic       scan_close;
		logic       depth_one;
		logic       mod_done;
		logic       clr_last;
		logic       out_free;
	} dp_sts_t;

	function automatic logic [63:0] cell_mask(input logic [1:0] code);
		logic [63:0] m;
		unique case (code)
			2'd0: m = 64'h0000_0000_0000_00FF;
			2'd1: m = 64'h0000_0000_0000_FFFF;
			2'd2: m = 64'h0000_0000_FFFF_FFFF;
			default: m = 64'hFFFF_FFFF_FFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

// ----- sv/tape_language_cpu_with_call_stack.sv -----
// Top level of the tape language processor with call stack.
// Execute request steps: accept, fetch, execute, result; a forward bracket scan adds a read
// and a check step per program byte walked, through the one program memory read port.
// Load request adds a modulo step, bytewise when PROG_DEPTH is not a power of two.
// Call also takes the modulo step; restart adds a pass that clears every data cell.
// After reset a clearing pass over the data memory holds req_stall high.
`timescale 1ns / 1ps

module tape_language_cpu_with_call_stack import tlc_pkg::*; #(
	parameter int PROG_DEPTH  = 4096,
	parameter int DATA_DEPTH  = 4096,
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	output logic       req_stall,
	input  req_t       req_data,
	output logic       rsp_valid,
	input  logic       rsp_stall,
	output rsp_t       rsp_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	tlc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	tlc_datapath #(
		.PROG_DEPTH  (PROG_DEPTH),
		.DATA_DEPTH  (DATA_DEPTH),
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.sts       (sts),
		.rsp_valid (rsp_valid),
		.rsp_data  (rsp_data)
	);

endmodule

// ----- sv/tlc_datapath.sv -----
// Datapath: program, data and return stack memories, pointers, scan and modulo units.
`timescale 1ns / 1ps

module tlc_datapath import tlc_pkg::*; #(
	parameter int PROG_DEPTH  = 4096,
	parameter int DATA_DEPTH  = 4096,
	parameter int STACK_DEPTH = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req_data,
	input  logic       cfg_we,
	input  logic [1:0] cfg_wdata,
	input  logic       rsp_stall,
	input  dp_cmd_t    cmd,
	output dp_sts_t    sts,
	output logic       rsp_valid,
	output rsp_t       rsp_data
);

	localparam int PAW = $clog2(PROG_DEPTH);
	localparam int DAW = $clog2(DATA_DEPTH);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int DPW = PAW + 1;
	localparam int MCW = PAW + 8;
	localparam bit PROG_POW2 = (PROG_DEPTH & (PROG_DEPTH - 1)) == 0;
	localparam logic [PAW-1:0] IP_LAST  = PAW'(PROG_DEPTH - 1);
	localparam logic [MCW-1:0] PD_MC    = MCW'(PROG_DEPTH);
	localparam logic [9:0]     RECIP    = 10'((64'd1 << MCW) / 64'(PROG_DEPTH));
	localparam logic [63:0]    DATA_LIM = 64'(DATA_DEPTH);
	localparam logic [SCW-1:0] SC_MAX   = SCW'(STACK_DEPTH);
	localparam logic [DAW-1:0] CLR_LAST = DAW'(DATA_DEPTH - 1);

	logic [7:0]     pm [PROG_DEPTH];
	logic [63:0]    dm [DATA_DEPTH];
	logic [PAW-1:0] stk [STACK_DEPTH];

	req_t           req_q;
	logic [1:0]     csize_q;
	logic [PAW-1:0] ip_q;
	logic [63:0]    dp_q;
	logic [SCW-1:0] sc_q;
	logic           halted_q;
	logic [7:0]     obyte_q;
	logic [7:0]     pm_rd_q;
	logic [63:0]    dm_rd_q;
	logic [PAW-1:0] stk_rd_q;
	logic [PAW-1:0] p_q;
	logic [DPW-1:0] depth_q;
	logic [63:0]    opnd_q;
	logic [PAW-1:0] mres_q;
	logic [MCW-1:0] mv_q;
	logic [9:0]     mq_q;
	logic [6:0]     mcnt_q;
	logic [DAW-1:0] clr_q;
	logic           out_valid_q;
	rsp_t           out_q;

	logic [63:0]    mask;
	logic [63:0]    cell_val;
	logic [PAW-1:0] pm_raddr;
	logic [PAW-1:0] p_nxt;
	logic [DAW-1:0] dp_idx;
	logic           dm_we;
	logic [DAW-1:0] dm_waddr;
	logic [63:0]    dm_wdata;
	logic           stk_we;
	logic [63:0]    mod_src;
	logic [MCW-1:0] mv;
	logic [MCW+9:0] mprod;
	logic [MCW-1:0] mrem;
	opc_t           opc;

	function automatic logic [PAW-1:0] ip_next(input logic [PAW-1:0] a);
		return (a == IP_LAST) ? '0 : a + PAW'(1);
	endfunction

	assign mask     = cell_mask(csize_q);
	assign cell_val = dm_rd_q & mask;
	assign dp_idx   = dp_q[DAW-1:0];
	assign p_nxt    = p_q + PAW'(1);
	assign pm_raddr = cmd.scan_rd ? p_nxt : ip_q;
	assign mod_src  = cmd.mod_sel_cell ? cell_val : 64'(req_q.prog_addr);
	assign mv       = {mres_q, opnd_q[63:56]};
	assign mprod    = (MCW + 10)'(mv) * (MCW + 10)'(RECIP);
	assign mrem     = mv_q - MCW'(mq_q) * PD_MC;

	always_comb begin
		unique case (pm_rd_q)
			8'h00:    opc = OPC_HALT;
			CH_RIGHT: opc = OPC_RIGHT;
			CH_LEFT:  opc = OPC_LEFT;
			CH_INC:   opc = OPC_INC;
			CH_DEC:   opc = OPC_DEC;
			CH_OUT:   opc = OPC_OUT;
			CH_IN:    opc = OPC_IN;
			CH_OPEN:  opc = OPC_OPEN;
			CH_CLOSE: opc = OPC_CLOSE;
			CH_GOTO:  opc = OPC_GOTO;
			CH_CALL:  opc = OPC_CALL;
			CH_RET:   opc = OPC_RET;
			CH_POP:   opc = OPC_POP;
			default:  opc = OPC_NOP;
		endcase
	end

	always_comb begin
		dm_we    = 1'b0;
		dm_waddr = dp_idx;
		dm_wdata = '0;
		if (cmd.clr_step) begin
			dm_we    = 1'b1;
			dm_waddr = clr_q;
		end else begin
			unique case (cmd.act)
				ACT_CELL_INC: begin
					dm_we    = 1'b1;
					dm_wdata = (cell_val + 64'd1) & mask;
				end
				ACT_CELL_DEC: begin
					dm_we    = 1'b1;
					dm_wdata = (cell_val - 64'd1) & mask;
				end
				ACT_CELL_IN: begin
					dm_we    = 1'b1;
					dm_wdata = 64'(req_q.in_byte) & mask;
				end
				default: ;
			endcase
		end
	end

	assign stk_we = (cmd.act == ACT_PUSH_ADV) || (cmd.act == ACT_CALL_PUSH);

	always_ff @(posedge clk) begin
		pm_rd_q <= pm[pm_raddr];
		if (cmd.act == ACT_PM_WR) begin
			pm[mres_q] <= req_q.prog_byte;
		end
	end

	always_ff @(posedge clk) begin
		dm_rd_q <= dm[dp_idx];
		if (dm_we) begin
			dm[dm_waddr] <= dm_wdata;
		end
	end

	always_ff @(posedge clk) begin
		stk_rd_q <= stk[SAW'(sc_q - SCW'(1))];
		if (stk_we) begin
			stk[sc_q[SAW-1:0]] <= ip_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			csize_q <= '0;
		end else if (cfg_we) begin
			csize_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q     <= '0;
			dp_q     <= '0;
			sc_q     <= '0;
			halted_q <= 1'b0;
			obyte_q  <= '0;
		end else begin
			if (cmd.latch) begin
				obyte_q <= '0;
			end
			unique case (cmd.act)
				ACT_ADV, ACT_CELL_INC, ACT_CELL_DEC, ACT_CELL_IN: ip_q <= ip_next(ip_q);
				ACT_DP_INC: begin
					dp_q <= (dp_q + 64'd1) & mask;
					ip_q <= ip_next(ip_q);
				end
				ACT_DP_DEC: begin
					dp_q <= (dp_q - 64'd1) & mask;
					ip_q <= ip_next(ip_q);
				end
				ACT_DP_SET: begin
					dp_q <= cell_val;
					ip_q <= ip_next(ip_q);
				end
				ACT_OUT: begin
					obyte_q <= cell_val[7:0];
					ip_q    <= ip_next(ip_q);
				end
				ACT_PUSH_ADV: begin
					sc_q <= sc_q + SCW'(1);
					ip_q <= ip_next(ip_q);
				end
				ACT_CALL_PUSH: sc_q <= sc_q + SCW'(1);
				ACT_LOOP_POP, ACT_POP: begin
					sc_q <= sc_q - SCW'(1);
					ip_q <= ip_next(ip_q);
				end
				ACT_LOOP_BACK: ip_q <= ip_next(stk_rd_q);
				ACT_RET: begin
					sc_q <= sc_q - SCW'(1);
					ip_q <= ip_next(stk_rd_q);
				end
				ACT_CALL_JUMP: ip_q <= ip_next(mres_q);
				ACT_SCAN_JUMP: ip_q <= ip_next(p_q);
				ACT_HALT:      halted_q <= 1'b1;
				ACT_RESTART: begin
					ip_q     <= '0;
					dp_q     <= '0;
					sc_q     <= '0;
					halted_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			p_q     <= ip_q;
			depth_q <= DPW'(1);
		end else if (cmd.scan_rd) begin
			p_q <= p_nxt;
		end else if (cmd.scan_chk) begin
			if (pm_rd_q == CH_OPEN) begin
				depth_q <= depth_q + DPW'(1);
			end else if (pm_rd_q == CH_CLOSE) begin
				depth_q <= depth_q - DPW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mcnt_q <= '0;
		end else if (cmd.mod_start) begin
			mcnt_q <= PROG_POW2 ? 7'd0 : 7'd16;
		end else if (mcnt_q != 7'd0) begin
			mcnt_q <= mcnt_q - 7'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mod_start) begin
			opnd_q <= mod_src;
			mres_q <= PROG_POW2 ? mod_src[PAW-1:0] : '0;
		end else if (mcnt_q != 7'd0) begin
			if (!mcnt_q[0]) begin
				mv_q <= mv;
				mq_q <= mprod[MCW+9:MCW];
			end else begin
				opnd_q <= {opnd_q[55:0], 8'd0};
				mres_q <= (mrem >= PD_MC) ? PAW'(mrem - PD_MC) : mrem[PAW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.act == ACT_RESTART) begin
			clr_q <= '0;
		end else if (cmd.clr_step) begin
			clr_q <= (clr_q == CLR_LAST) ? '0 : clr_q + DAW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			out_q.status          <= cmd.res_code;
			out_q.out_byte        <= obyte_q;
			out_q.program_counter <= 12'(ip_q);
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	always_comb begin
		sts.func        = req_q.func;
		sts.opc         = opc;
		sts.halted      = halted_q;
		sts.cell_zero   = (cell_val == 64'd0);
		sts.dp_oor      = (dp_q >= DATA_LIM);
		sts.sc_empty    = (sc_q == '0);
		sts.sc_full     = (sc_q >= SC_MAX);
		sts.in_avail    = req_q.in_valid;
		sts.scan_at_end = (p_q == IP_LAST);
		sts.scan_zero   = (pm_rd_q == 8'h00);
		sts.scan_close  = (pm_rd_q == CH_CLOSE);
		sts.depth_one   = (depth_q == DPW'(1));
		sts.mod_done    = (mcnt_q == 7'd0);
		sts.clr_last    = (clr_q == CLR_LAST);
		sts.out_free    = !out_valid_q || !rsp_stall;
	end

endmodule

// ----- sv/tlc_ctrl.sv -----
// Controller: sequences each request through fetch, execute, scan, modulo and clear steps.
`timescale 1ns / 1ps

module tlc_ctrl import tlc_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [3:0] {
		S_CLR_BOOT, S_IDLE, S_DISPATCH, S_EXEC, S_SCAN_RD, S_SCAN_CHK,
		S_MOD, S_CLR_RST, S_DONE
	} state_t;

	state_t     state_q, state_d;
	logic [2:0] code_q, code_d;
	logic       uses_cell;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		uses_cell = (sts.opc == OPC_INC) || (sts.opc == OPC_DEC) ||
			(sts.opc == OPC_OUT) || (sts.opc == OPC_IN) ||
			(sts.opc == OPC_OPEN) || (sts.opc == OPC_CLOSE) ||
			(sts.opc == OPC_GOTO) || (sts.opc == OPC_CALL);
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		code_d  = code_q;
		unique case (state_q)
			S_CLR_BOOT: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DISPATCH;
				end
			end
			S_DISPATCH: begin
				code_d = ST_STEPPED;
				priority case (sts.func)
					FN_LOAD: begin
						cmd.mod_start = 1'b1;
						state_d       = S_MOD;
					end
					FN_EXEC: state_d = S_EXEC;
					FN_RESTART: begin
						cmd.act = ACT_RESTART;
						state_d = S_CLR_RST;
					end
					default: state_d = S_DONE;
				endcase
			end
			S_EXEC: begin
				state_d = S_DONE;
				code_d  = ST_STEPPED;
				priority if (sts.halted) begin
					code_d = ST_HALTED;
				end else if (sts.opc == OPC_HALT) begin
					cmd.act = ACT_HALT;
					code_d  = ST_HALTED;
				end else if (sts.opc == OPC_CLOSE && sts.sc_empty) begin
					code_d = ST_STK_EMPTY;
				end else if (uses_cell && sts.dp_oor) begin
					code_d = ST_PTR_RANGE;
				end else begin
					unique case (sts.opc)
						OPC_RIGHT: cmd.act = ACT_DP_INC;
						OPC_LEFT:  cmd.act = ACT_DP_DEC;
						OPC_INC:   cmd.act = ACT_CELL_INC;
						OPC_DEC:   cmd.act = ACT_CELL_DEC;
						OPC_OUT: begin
							cmd.act = ACT_OUT;
							code_d  = ST_BYTE_OUT;
						end
						OPC_IN: begin
							if (sts.in_avail) begin
								cmd.act = ACT_CELL_IN;
							end else begin
								code_d = ST_NEED_IN;
							end
						end
						OPC_OPEN: begin
							if (!sts.cell_zero) begin
								if (sts.sc_full) begin
									code_d = ST_STK_OVF;
								end else begin
									cmd.act = ACT_PUSH_ADV;
								end
							end else begin
								cmd.scan_start = 1'b1;
								state_d        = S_SCAN_RD;
							end
						end
						OPC_CLOSE: cmd.act = sts.cell_zero ? ACT_LOOP_POP : ACT_LOOP_BACK;
						OPC_GOTO:  cmd.act = ACT_DP_SET;
						OPC_CALL: begin
							if (sts.sc_full) begin
								code_d = ST_STK_OVF;
							end else begin
								cmd.act          = ACT_CALL_PUSH;
								cmd.mod_start    = 1'b1;
								cmd.mod_sel_cell = 1'b1;
								state_d          = S_MOD;
							end
						end
						OPC_RET: begin
							if (sts.sc_empty) begin
								code_d = ST_STK_EMPTY;
							end else begin
								cmd.act = ACT_RET;
							end
						end
						OPC_POP: begin
							if (sts.sc_empty) begin
								code_d = ST_STK_EMPTY;
							end else begin
								cmd.act = ACT_POP;
							end
						end
						OPC_NOP:  cmd.act = ACT_ADV;
						OPC_HALT: cmd.act = ACT_NONE;
					endcase
				end
			end
			S_SCAN_RD: begin
				if (sts.scan_at_end) begin
					code_d  = ST_UNMATCHED;
					state_d = S_DONE;
				end else begin
					cmd.scan_rd = 1'b1;
					state_d     = S_SCAN_CHK;
				end
			end
			S_SCAN_CHK: begin
				priority if (sts.scan_zero) begin
					code_d  = ST_UNMATCHED;
					state_d = S_DONE;
				end else if (sts.scan_close && sts.depth_one) begin
					cmd.act = ACT_SCAN_JUMP;
					state_d = S_DONE;
				end else begin
					cmd.scan_chk = 1'b1;
					state_d      = S_SCAN_RD;
				end
			end
			S_MOD: begin
				if (sts.mod_done) begin
					cmd.act = (sts.func == FN_LOAD) ? ACT_PM_WR : ACT_CALL_JUMP;
					state_d = S_DONE;
				end
			end
			S_CLR_RST: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					cmd.res_code = code_q;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR_BOOT;
			code_q  <= ST_STEPPED;
		end else begin
			state_q <= state_d;
			code_q  <= code_d;
		end
	end

endmodule

// ----- sv/tlc_checker.sv -----
// Port-level checker for the tape language processor, bound to the top level.
`timescale 1ns / 1ps

module tlc_checker import tlc_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_stall,
	input logic       rsp_valid,
	input logic       rsp_stall,
	input rsp_t       rsp_data
);

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request accepted while another is in flight");

	a_out_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.status != ST_BYTE_OUT |-> rsp_data.out_byte == 8'd0)
		else $error("out_byte set without byte output status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
		else $error("stalled response changed");

	a_rsp_taken: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(rsp_valid) |-> $past(!rsp_stall))
		else $error("response dropped without being taken");

endmodule

bind tape_language_cpu_with_call_stack tlc_checker u_tlc_checker (.*);
